// ===== hw/rtl/max_heap_with_overflow_evict_unit_assert.svh =====
// assertion macros for the heap unit, clocked on aclk and disabled in reset
`ifndef MAX_HEAP_WITH_OVERFLOW_EVICT_UNIT_ASSERT_SVH
`define MAX_HEAP_WITH_OVERFLOW_EVICT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MHE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("heap unit check failed");
`define MHE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("heap unit sequencing check failed");
`else
`define MHE_ASSERT_NOW(lbl, ante, cons)
`define MHE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/mhe_pkg.sv =====
`default_nettype none
package mhe_pkg;

    localparam int CAPACITY   = 64;
    localparam int SCORE_BITS = 24;
    localparam int ID_W       = 6;
    localparam int COST_W     = 48;
    localparam int SUM_W      = 31;
    localparam int THR_W      = 32;
    localparam int MMC_W      = 7;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    // child indices reach 2*CAPACITY
    localparam int CMP_W      = IDX_W + 2;
    localparam int ROOM_W     = ((CNT_W > MMC_W) ? CNT_W : MMC_W) + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCH = 1'b1;

    localparam logic [1:0] RD_TOP      = 2'd0;
    localparam logic [1:0] RD_PARENT   = 2'd1;
    localparam logic [1:0] RD_CHILDREN = 2'd2;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_NODE = 2'd1;
    localparam logic [1:0] WR_RDA  = 2'd2;
    localparam logic [1:0] WR_PICK = 2'd3;

    localparam logic [2:0] POS_HOLD   = 3'd0;
    localparam logic [2:0] POS_COUNT  = 3'd1;
    localparam logic [2:0] POS_ZERO   = 3'd2;
    localparam logic [2:0] POS_PARENT = 3'd3;
    localparam logic [2:0] POS_PICK   = 3'd4;

    localparam logic [1:0] NODE_HOLD = 2'd0;
    localparam logic [1:0] NODE_IN   = 2'd1;
    localparam logic [1:0] NODE_LAST = 2'd2;

    localparam logic [1:0] RES_HOLD = 2'd0;
    localparam logic [1:0] RES_NONE = 2'd1;
    localparam logic [1:0] RES_IN   = 2'd2;
    localparam logic [1:0] RES_TOP  = 2'd3;

    localparam logic [1:0] SUM_HOLD = 2'd0;
    localparam logic [1:0] SUM_ADD  = 2'd1;
    localparam logic [1:0] SUM_POP  = 2'd2;
    localparam logic [1:0] SUM_SWAP = 2'd3;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [SCORE_BITS-1:0] score;
        logic [COST_W-1:0]     cost;
    } entry_t;

    typedef struct packed {
        logic                capture;
        logic [1:0]          rd_sel;
        logic [1:0]          wr_sel;
        logic [2:0]          pos_sel;
        logic [1:0]          node_sel;
        logic [1:0]          res_sel;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          sum_sel;
        logic [1:0]          cnt_sel;
        logic                out_load;
    } mhe_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic cnt_zero;
        logic room;
        logic full;
        logic pos_zero;
        logic child_out;
        logic up_gt;
        logic dn_gt;
        logic top_gt;
    } mhe_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mhe_ram.sv =====
`default_nettype none
module mhe_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]  rd_data_a,
    output logic      [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mhe_datapath.sv =====
`default_nettype none
module mhe_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_operation,
    input  wire logic [mhe_pkg::ID_W-1:0]        s_entry_id,
    input  wire logic [mhe_pkg::SCORE_BITS-1:0]  s_entry_score,
    input  wire logic [mhe_pkg::COST_W-1:0]      s_entry_cost,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mhe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mhe_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire mhe_pkg::mhe_cmd_t               cmd,
    output mhe_pkg::mhe_stat_t                   stat,
    output logic                                 m_out_valid,
    output logic      [mhe_pkg::ID_W-1:0]        m_out_id,
    output logic      [mhe_pkg::SCORE_BITS-1:0]  m_out_score,
    output logic      [mhe_pkg::COST_W-1:0]      m_out_cost,
    output logic      [mhe_pkg::CNT_W-1:0]       m_held_count,
    output logic      [mhe_pkg::SUM_W-1:0]       m_held_score_sum,
    output logic      [mhe_pkg::STATUS_W-1:0]    m_status
);
    import mhe_pkg::*;

    localparam int T_W = SUM_W + 2;
    localparam logic [T_W-1:0] SUM_MAX = T_W'({SUM_W{1'b1}});

    function automatic logic is_greater(input entry_t a, input entry_t b);
        logic result;
        if (a.score != b.score) begin
            result = a.score > b.score;
        end else begin
            result = a.cost < b.cost;
        end
        return result;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(
        input logic [SUM_W-1:0]      base,
        input logic [SCORE_BITS-1:0] add,
        input logic [SCORE_BITS-1:0] sub
    );
        logic [T_W-1:0] t;
        logic [T_W-1:0] s;
        logic [SUM_W-1:0] result;
        t = T_W'(base) + T_W'(add);
        s = T_W'(sub);
        if (t < s) begin
            result = '0;
        end else if ((t - s) > SUM_MAX) begin
            result = SUM_MAX[SUM_W-1:0];
        end else begin
            result = SUM_W'(t - s);
        end
        return result;
    endfunction

    entry_t              in_reg;
    logic                op_reg;
    entry_t              node_reg,   node_next;
    logic [IDX_W-1:0]    pos_reg,    pos_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [SUM_W-1:0]    sum_reg,    sum_next;
    logic [THR_W-1:0]    thr_reg;
    logic [MMC_W-1:0]    mmc_reg;
    entry_t              res_reg,    res_next;
    logic                resv_reg,   resv_next;
    logic [STATUS_W-1:0] ress_reg,   ress_next;
    entry_t              out_reg;
    logic                outv_reg;
    logic [CNT_W-1:0]    outc_reg;
    logic [SUM_W-1:0]    outs_reg;
    logic [STATUS_W-1:0] outst_reg;

    entry_t           rd_a;
    entry_t           rd_b;
    entry_t           wr_data;
    entry_t           pick;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic [IDX_W-1:0] parent_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] pick_idx;
    logic [CMP_W-1:0] child;
    logic [CMP_W-1:0] child1;
    logic [CMP_W-1:0] cnt_ext;
    logic             has_right;
    logic             pick_right;
    logic [THR_W:0]   room_sum;

    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign last_idx   = IDX_W'(cnt_reg - CNT_W'(1));
    assign child      = {1'b0, pos_reg, 1'b1};
    assign child1     = child + CMP_W'(1);
    assign cnt_ext    = CMP_W'(cnt_reg);
    assign has_right  = child1 < cnt_ext;
    assign pick_right = has_right && is_greater(rd_b, rd_a);
    assign pick       = pick_right ? rd_b : rd_a;
    assign pick_idx   = pick_right ? child1[IDX_W-1:0] : child[IDX_W-1:0];
    assign room_sum   = (THR_W + 1)'(sum_reg) + (THR_W + 1)'(in_reg.score);

    always_comb begin
        case (cmd.rd_sel)
            RD_TOP: begin
                rd_addr_a = '0;
                rd_addr_b = last_idx;
            end
            RD_PARENT: begin
                rd_addr_a = parent_idx;
                rd_addr_b = parent_idx;
            end
            RD_CHILDREN: begin
                rd_addr_a = child[IDX_W-1:0];
                rd_addr_b = has_right ? child1[IDX_W-1:0] : child[IDX_W-1:0];
            end
            default: begin
                rd_addr_a = '0;
                rd_addr_b = '0;
            end
        endcase
    end

    always_comb begin
        wr_en = cmd.wr_sel != WR_NONE;
        case (cmd.wr_sel)
            WR_RDA:  wr_data = rd_a;
            WR_PICK: wr_data = pick;
            default: wr_data = node_reg;
        endcase
    end

    mhe_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY),
        .ADDR_W(IDX_W)
    ) u_heap_ram (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (pos_reg),
        .wr_data  (wr_data),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(rd_a),
        .rd_data_b(rd_b)
    );

    always_comb begin
        stat.is_pop    = op_reg == OP_POP;
        stat.cnt_zero  = cnt_reg == '0;
        stat.room      = (room_sum < (THR_W + 1)'(thr_reg))
                      || ((ROOM_W'(cnt_reg) + ROOM_W'(1)) < ROOM_W'(mmc_reg));
        stat.full      = cnt_reg == CNT_W'(CAPACITY);
        stat.pos_zero  = pos_reg == '0;
        stat.child_out = child >= cnt_ext;
        stat.up_gt     = is_greater(node_reg, rd_a);
        stat.dn_gt     = is_greater(pick, node_reg);
        stat.top_gt    = is_greater(rd_a, in_reg);
    end

    always_comb begin
        node_next = node_reg;
        case (cmd.node_sel)
            NODE_IN:   node_next = in_reg;
            NODE_LAST: node_next = rd_b;
            default: ;
        endcase

        pos_next = pos_reg;
        case (cmd.pos_sel)
            POS_COUNT:  pos_next = IDX_W'(cnt_reg);
            POS_ZERO:   pos_next = '0;
            POS_PARENT: pos_next = parent_idx;
            POS_PICK:   pos_next = pick_idx;
            default: ;
        endcase

        cnt_next = cnt_reg;
        case (cmd.cnt_sel)
            CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC: cnt_next = cnt_reg - CNT_W'(1);
            default: ;
        endcase

        sum_next = sum_reg;
        case (cmd.sum_sel)
            SUM_ADD:  sum_next = sat_sum(sum_reg, in_reg.score, '0);
            SUM_POP:  sum_next = sat_sum(sum_reg, '0, rd_a.score);
            SUM_SWAP: sum_next = sat_sum(sum_reg, in_reg.score, rd_a.score);
            default: ;
        endcase

        res_next  = res_reg;
        resv_next = resv_reg;
        ress_next = ress_reg;
        case (cmd.res_sel)
            RES_NONE: begin
                res_next  = '0;
                resv_next = 1'b0;
                ress_next = cmd.res_status;
            end
            RES_IN: begin
                res_next  = in_reg;
                resv_next = 1'b1;
                ress_next = cmd.res_status;
            end
            RES_TOP: begin
                res_next  = rd_a;
                resv_next = 1'b1;
                ress_next = cmd.res_status;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
            thr_reg <= '0;
            mmc_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg <= cfg_wdata;
                    CFG_MIN_MATCH: mmc_reg <= cfg_wdata[MMC_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= s_operation;
            in_reg.id    <= s_entry_id;
            in_reg.score <= s_entry_score;
            in_reg.cost  <= s_entry_cost;
        end
        node_reg <= node_next;
        pos_reg  <= pos_next;
        res_reg  <= res_next;
        resv_reg <= resv_next;
        ress_reg <= ress_next;
        if (cmd.out_load) begin
            out_reg   <= res_reg;
            outv_reg  <= resv_reg;
            outc_reg  <= cnt_reg;
            outs_reg  <= sum_reg;
            outst_reg <= ress_reg;
        end
    end

    assign m_out_valid      = outv_reg;
    assign m_out_id         = out_reg.id;
    assign m_out_score      = out_reg.score;
    assign m_out_cost       = out_reg.cost;
    assign m_held_count     = outc_reg;
    assign m_held_score_sum = outs_reg;
    assign m_status         = outst_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mhe_controller.sv =====
`default_nettype none
module mhe_controller (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire mhe_pkg::mhe_stat_t stat,
    output mhe_pkg::mhe_cmd_t       cmd
);
    import mhe_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_POP_TOP = 4'd2;
    localparam logic [3:0] S_TOP_CHK = 4'd3;
    localparam logic [3:0] S_UP_CHK  = 4'd4;
    localparam logic [3:0] S_UP_CMP  = 4'd5;
    localparam logic [3:0] S_DN_CHK  = 4'd6;
    localparam logic [3:0] S_DN_CMP  = 4'd7;
    localparam logic [3:0] S_FINISH  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.is_pop) begin
                    if (stat.cnt_zero) begin
                        cmd.res_sel    = RES_NONE;
                        cmd.res_status = ST_EMPTY;
                        state_next     = S_FINISH;
                    end else begin
                        cmd.rd_sel = RD_TOP;
                        state_next = S_POP_TOP;
                    end
                end else if (stat.room) begin
                    if (stat.full) begin
                        cmd.res_sel    = RES_IN;
                        cmd.res_status = ST_FULL;
                        state_next     = S_FINISH;
                    end else begin
                        // append at the tail, then sift up
                        cmd.pos_sel  = POS_COUNT;
                        cmd.node_sel = NODE_IN;
                        cmd.cnt_sel  = CNT_INC;
                        cmd.sum_sel  = SUM_ADD;
                        cmd.res_sel  = RES_NONE;
                        state_next   = S_UP_CHK;
                    end
                end else if (stat.cnt_zero) begin
                    cmd.res_sel = RES_IN;
                    state_next  = S_FINISH;
                end else begin
                    cmd.rd_sel = RD_TOP;
                    state_next = S_TOP_CHK;
                end
            end
            S_POP_TOP: begin
                // top on port a, last entry on port b
                cmd.res_sel  = RES_TOP;
                cmd.node_sel = NODE_LAST;
                cmd.cnt_sel  = CNT_DEC;
                cmd.sum_sel  = SUM_POP;
                cmd.pos_sel  = POS_ZERO;
                state_next   = S_DN_CHK;
            end
            S_TOP_CHK: begin
                if (stat.top_gt) begin
                    cmd.res_sel  = RES_TOP;
                    cmd.node_sel = NODE_IN;
                    cmd.pos_sel  = POS_ZERO;
                    cmd.sum_sel  = SUM_SWAP;
                    state_next   = S_DN_CHK;
                end else begin
                    cmd.res_sel = RES_IN;
                    state_next  = S_FINISH;
                end
            end
            S_UP_CHK: begin
                if (stat.pos_zero) begin
                    cmd.wr_sel = WR_NODE;
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (stat.up_gt) begin
                    cmd.wr_sel  = WR_RDA;
                    cmd.pos_sel = POS_PARENT;
                    state_next  = S_UP_CHK;
                end else begin
                    cmd.wr_sel = WR_NODE;
                    state_next = S_FINISH;
                end
            end
            S_DN_CHK: begin
                if (stat.child_out) begin
                    cmd.wr_sel = WR_NODE;
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_sel = RD_CHILDREN;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (stat.dn_gt) begin
                    cmd.wr_sel  = WR_PICK;
                    cmd.pos_sel = POS_PICK;
                    state_next  = S_DN_CHK;
                end else begin
                    cmd.wr_sel = WR_NODE;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/max_heap_with_overflow_evict_unit.sv =====
// Bounded max-heap of (id, score, cost) entries with overflow eviction.
// Requests enter on the s_ channel (valid/ready): s_operation selects an insert
// or a pop of the top entry. Every request yields exactly one result on the m_
// channel (valid/ready) carrying the evicted or popped entry, the held count,
// the saturating held score sum and a status code.
// Configuration (competitive threshold, minimum match count) is written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while no request is
// in flight, as the block itself does not enforce this. One request is processed
// at a time. Pops on an empty heap, full-heap inserts and inserts evicted from an
// empty heap go from decode straight to the finish state; a newcomer that loses
// to the top is first compared against it. An append sifts up parent by parent
// and a pop or top replacement sifts down child level by child level; each level
// costs one registered read of the heap memory and one compare/write step. s_ready
// rises with m_valid. If the receiver stalls, the finished result waits in the
// output register and a following request finishes its heap update, then waits
// until m_ready frees it. Reset empties the heap (count and sum zero) and clears
// both config registers; the heap memory itself is not cleared.
`default_nettype none
`include "max_heap_with_overflow_evict_unit_assert.svh"
module max_heap_with_overflow_evict_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_operation,
    input  wire logic [mhe_pkg::ID_W-1:0]        s_entry_id,
    input  wire logic [mhe_pkg::SCORE_BITS-1:0]  s_entry_score,
    input  wire logic [mhe_pkg::COST_W-1:0]      s_entry_cost,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_out_valid,
    output logic      [mhe_pkg::ID_W-1:0]        m_out_id,
    output logic      [mhe_pkg::SCORE_BITS-1:0]  m_out_score,
    output logic      [mhe_pkg::COST_W-1:0]      m_out_cost,
    output logic      [mhe_pkg::CNT_W-1:0]       m_held_count,
    output logic      [mhe_pkg::SUM_W-1:0]       m_held_score_sum,
    output logic      [mhe_pkg::STATUS_W-1:0]    m_status,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mhe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mhe_pkg::CFG_W-1:0]       cfg_wdata
);
    import mhe_pkg::*;

    mhe_cmd_t  cmd;
    mhe_stat_t stat;

    mhe_controller u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    mhe_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_operation     (s_operation),
        .s_entry_id      (s_entry_id),
        .s_entry_score   (s_entry_score),
        .s_entry_cost    (s_entry_cost),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .stat            (stat),
        .m_out_valid     (m_out_valid),
        .m_out_id        (m_out_id),
        .m_out_score     (m_out_score),
        .m_out_cost      (m_out_cost),
        .m_held_count    (m_held_count),
        .m_held_score_sum(m_held_score_sum),
        .m_status        (m_status)
    );

    `MHE_ASSERT_NEXT(a_one_request_in_flight, s_valid && s_ready, !s_ready)
    `MHE_ASSERT_NOW(a_no_result_overwrite, m_valid && !m_ready, !cmd.out_load)
    `MHE_ASSERT_NOW(a_count_bound, m_valid, m_held_count <= CNT_W'(CAPACITY))
    `MHE_ASSERT_NOW(a_empty_payload, m_valid && !m_out_valid,
        m_out_id == '0 && m_out_score == '0 && m_out_cost == '0)
    `MHE_ASSERT_NOW(a_full_status, m_valid && m_status == ST_FULL,
        m_out_valid && m_held_count == CNT_W'(CAPACITY))

endmodule
`default_nettype wire

// ===== verif/max_heap_with_overflow_evict_unit_tb.sv =====
`default_nettype none
module max_heap_with_overflow_evict_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhe_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam longint unsigned SUM_LIMIT = 64'd2147483647;
    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef struct packed {
        logic                valid;
        entry_t              item;
        logic [CNT_W-1:0]    count;
        logic [SUM_W-1:0]    sum;
        logic [STATUS_W-1:0] status;
    } heap_response_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = OP_INSERT;
    logic [ID_W-1:0]       s_entry_id = '0;
    logic [SCORE_BITS-1:0] s_entry_score = '0;
    logic [COST_W-1:0]     s_entry_cost = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_out_valid;
    logic [ID_W-1:0]       m_out_id;
    logic [SCORE_BITS-1:0] m_out_score;
    logic [COST_W-1:0]     m_out_cost;
    logic [CNT_W-1:0]      m_held_count;
    logic [SUM_W-1:0]      m_held_score_sum;
    logic [STATUS_W-1:0]   m_status;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_THRESHOLD;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // heap mirror and configuration copy
    entry_t          heap_model [CAPACITY];
    int              heap_size = 0;
    longint unsigned held_sum = 0;
    longint unsigned threshold_reg = 0;
    int              min_match_reg = 0;

    heap_response_t  pending_responses [$];
    heap_response_t  want_response;
    int              mismatches = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              stall_request = 0;
    int              hold_left = 0;
    int              quiet_cycles = 0;

    max_heap_with_overflow_evict_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_entry_id       (s_entry_id),
        .s_entry_score    (s_entry_score),
        .s_entry_cost     (s_entry_cost),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_valid      (m_out_valid),
        .m_out_id         (m_out_id),
        .m_out_score      (m_out_score),
        .m_out_cost       (m_out_cost),
        .m_held_count     (m_held_count),
        .m_held_score_sum (m_held_score_sum),
        .m_status         (m_status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always #5ns aclk = ~aclk;

    function automatic bit outranks(entry_t a, entry_t b);
        if (a.score != b.score)
            return a.score > b.score;
        return a.cost < b.cost;
    endfunction

    function automatic longint unsigned clamp_sum(longint unsigned base, longint unsigned add,
                                                  longint unsigned sub);
        longint unsigned t;
        t = base + add;
        if (t < sub)
            return 0;
        t -= sub;
        return (t > SUM_LIMIT) ? SUM_LIMIT : t;
    endfunction

    function automatic void model_sift_up(int pos);
        entry_t node;
        int     parent;
        node = heap_model[pos];
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!outranks(node, heap_model[parent]))
                break;
            heap_model[pos] = heap_model[parent];
            pos = parent;
        end
        heap_model[pos] = node;
    endfunction

    function automatic void model_sift_down();
        entry_t node;
        int     pos;
        int     child;
        if (heap_size == 0)
            return;
        pos = 0;
        node = heap_model[0];
        forever begin
            child = 2 * pos + 1;
            if (child >= heap_size)
                break;
            if (child + 1 < heap_size && outranks(heap_model[child + 1], heap_model[child]))
                child++;
            if (!outranks(heap_model[child], node))
                break;
            heap_model[pos] = heap_model[child];
            pos = child;
        end
        heap_model[pos] = node;
    endfunction

    function automatic heap_response_t predict_heap_response(logic op, entry_t e);
        heap_response_t r;
        entry_t         top;
        r = '0;
        r.status = ST_OK;
        if (op == OP_POP) begin
            if (heap_size == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.valid = 1'b1;
                r.item = heap_model[0];
                heap_size--;
                heap_model[0] = heap_model[heap_size];
                model_sift_down();
                held_sum = clamp_sum(held_sum, 0, r.item.score);
            end
        end else if (held_sum + e.score < threshold_reg || heap_size + 1 < min_match_reg) begin
            if (heap_size >= CAPACITY) begin
                r.valid = 1'b1;
                r.item = e;
                r.status = ST_FULL;
            end else begin
                heap_model[heap_size] = e;
                model_sift_up(heap_size);
                heap_size++;
                held_sum = clamp_sum(held_sum, e.score, 0);
            end
        end else if (heap_size == 0) begin
            r.valid = 1'b1;
            r.item = e;
        end else begin
            top = heap_model[0];
            r.valid = 1'b1;
            if (!outranks(top, e)) begin
                r.item = e;
            end else begin
                heap_model[0] = e;
                model_sift_down();
                held_sum = clamp_sum(held_sum, e.score, top.score);
                r.item = top;
            end
        end
        r.count = CNT_W'(heap_size);
        r.sum = SUM_W'(held_sum);
        return r;
    endfunction

    function automatic entry_t random_entry();
        entry_t e;
        int     pick;
        pick = $urandom_range(99);
        e.id = ID_W'($urandom());
        if (pick < 45) begin
            e.score = SCORE_BITS'($urandom());
            e.cost = COST_W'({$urandom(), $urandom()});
        end else if (pick < 80) begin
            // narrow values so score ties hit the cost ordering
            e.score = SCORE_BITS'($urandom_range(7));
            e.cost = COST_W'($urandom_range(3));
        end else begin
            e.score = $urandom_range(1) ? SCORE_MAX : '0;
            e.cost = $urandom_range(1) ? COST_MAX : COST_W'($urandom_range(1));
        end
        return e;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_request(input logic op, input entry_t e);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_entry_id    <= e.id;
        s_entry_score <= e.score;
        s_entry_cost  <= e.cost;
        do @(posedge aclk); while (!s_ready);
        pending_responses.push_back(predict_heap_response(op, e));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] thr, input logic [MMC_W-1:0] mmc);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_index <= CFG_MIN_MATCH;
        // bits above the register width are don't-care
        cfg_wdata <= ($urandom() << MMC_W) | CFG_W'(mmc);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        threshold_reg = 64'(thr);
        min_match_reg = int'(mmc);
    endtask

    task automatic test_directed_cases();
        entry_t dup;
        drain_results();
        // reset config: no room, so an insert into the empty heap is evicted
        send_request(OP_POP, '1);
        send_request(OP_INSERT, '1);
        drain_results();
        apply_settings('1, '0);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '{6'd63, SCORE_MAX, 48'd0});
        send_request(OP_INSERT, '{6'd5, 24'd1000, 48'd7});
        send_request(OP_INSERT, '{6'd6, 24'd1000, 48'd3});
        send_request(OP_INSERT, '{6'd7, 24'd1000, COST_MAX});
        send_request(OP_INSERT, '{6'd8, SCORE_MAX, COST_MAX});
        repeat (3) send_request(OP_POP, '1);
        drain_results();
        apply_settings(32'd1, '0);
        // overflow: weaker newcomer replaces the top, then a duplicate of the top and a stronger newcomer lose
        send_request(OP_INSERT, '{6'd9, 24'd0, COST_MAX});
        dup = heap_model[0];
        send_request(OP_INSERT, dup);
        send_request(OP_INSERT, '{6'd10, SCORE_MAX, 48'd0});
        drain_results();
        apply_settings('0, MMC_W'(CAPACITY));
        send_request(OP_INSERT, '{6'd11, 24'd500, 48'd1});
        send_request(OP_INSERT, '{6'd12, 24'd500, 48'd0});
        while (heap_size > 0)
            send_request(OP_POP, '0);
        send_request(OP_POP, '0);
    endtask

    task automatic test_fill_to_capacity();
        drain_results();
        apply_settings('1, '0);
        while (heap_size < CAPACITY)
            send_request(OP_INSERT, random_entry());
        repeat (2) send_request(OP_INSERT, random_entry());
        while (heap_size > 0)
            send_request(OP_POP, random_entry());
        send_request(OP_POP, random_entry());
    endtask

    task automatic test_random_traffic(input int count, input logic [CFG_W-1:0] thr,
                                       input logic [MMC_W-1:0] mmc, input int pop_pct);
        drain_results();
        apply_settings(thr, mmc);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < pop_pct)
                send_request(OP_POP, random_entry());
            else
                send_request(OP_INSERT, random_entry());
            if ($urandom_range(99) == 0)
                drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        drain_results();
        // receiver holds off long enough for the input side to stall
        stall_request = 300;
        for (int k = 0; k < 24; k++) begin
            if ($urandom_range(2) == 0)
                send_request(OP_POP, random_entry());
            else
                send_request(OP_INSERT, random_entry());
        end
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: response with no request outstanding, expected none, actual id %0h",
                         $time, m_out_id);
                mismatches++;
            end else begin
                want_response = pending_responses.pop_front();
                check_field("out_valid", 64'(want_response.valid), 64'(m_out_valid));
                check_field("out_id", 64'(want_response.item.id), 64'(m_out_id));
                check_field("out_score", 64'(want_response.item.score), 64'(m_out_score));
                check_field("out_cost", 64'(want_response.item.cost), 64'(m_out_cost));
                check_field("held_count", 64'(want_response.count), 64'(m_held_count));
                check_field("held_score_sum", 64'(want_response.sum), 64'(m_held_score_sum));
                check_field("status", 64'(want_response.status), 64'(m_status));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 53;
        test_directed_cases();
        test_fill_to_capacity();
        test_random_traffic(120, $urandom_range(600000000), MMC_W'($urandom_range(CAPACITY)),
                            40);
        test_random_traffic(110, '1, '0, 25);

        send_idle_pct = 53;
        recv_idle_pct = 21;
        test_random_traffic(120, '0, MMC_W'(CAPACITY), 40);
        test_random_traffic(110, $urandom(), MMC_W'($urandom_range(CAPACITY)), 50);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(120, '0, '0, 30);
        test_random_traffic(120, $urandom_range(50000000), '0, 35);

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
